// File: rtl/frml_pkg.sv
// ----------------------------------------------------------------------------
// frml_pkg: shared types and constants of the frame RMS level meter
// Command and status bundles between controller and datapath, controller
// states, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package frml_pkg;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 13;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_LENGTH = 2'd1;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] FRAME_LENGTH_RST  = 13'd1024;
    localparam logic [CFG_W-1:0] PACKET_LENGTH_RST = 13'd60;

    // result field
    localparam int LEVEL_W = 16;

    // controller states
    typedef enum logic [2:0] {
        S_ACC,      // accumulating samples
        S_FINISH,   // fold last square into the sum, load divider
        S_DIV,      // restoring divide, one quotient bit per cycle
        S_SQ_LOAD,  // move quotient into the root unit
        S_SQRT,     // digit-by-digit root, one root bit per cycle
        S_OUT       // wait for the output register to be free
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic acc;       // sample transaction this cycle
        logic finish;    // close the frame
        logic div_step;  // one divide iteration
        logic sq_load;   // load the root unit
        logic sq_step;   // one root iteration
        logic out_load;  // write the result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic close;      // the sample on the input closes the frame
        logic step_last;  // current iteration is the last of its phase
        logic out_free;   // result register can take a new result
    } t_dp_sts;

endpackage

// File: rtl/frame_rms_level_meter.sv
// ----------------------------------------------------------------------------
// frame_rms_level_meter: frame RMS level meter
// Accumulates squares of signed PCM samples over a frame and emits
// floor(sqrt(floor(sum / count))) per frame, with a packet end flag.
//
//   channel   dir  handshake        payload
//   s_axis    in   tvalid/tready    tdata: sample
//   m_axis    out  tvalid/tready    tdata: rms_level, tlast: packet_end
//   cfg       in   i_cfg_we         i_cfg_idx, i_cfg_data
//
// Samples that do not close a frame are accepted back to back.
// The sample that closes a frame stalls the input through
// D = 2*SAMPLE_BITS-2+clog2(MAX_FRAME_LENGTH+1) divide iterations
// and R = ceil(D/2) root iterations of the bit-serial divider and root
// unit; a full result register holds the input until m_axis_tready.
// Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module frame_rms_level_meter #(
    parameter int MAX_FRAME_LENGTH = 4096,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [frml_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [frml_pkg::CFG_W-1:0]            i_cfg_data,
    // sample stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,   // sample
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [frml_pkg::LEVEL_W-1:0]          m_axis_tdata,   // rms_level
    output logic                                  m_axis_tlast    // packet_end
);
    import frml_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    frml_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample_vld (s_axis_tvalid),
        .o_sample_rdy (s_axis_tready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    // arithmetic and result register
    frml_datapath #(
        .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample     (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_rdy    (m_axis_tready),
        .o_out_vld    (m_axis_tvalid),
        .o_level      (m_axis_tdata),
        .o_packet_end (m_axis_tlast)
    );

endmodule

// File: rtl/frml_ctrl.sv
// ----------------------------------------------------------------------------
// frml_ctrl: sequencer of the frame RMS level meter
// Accepts samples while accumulating, then walks the divide and root
// iterations and hands the finished level to the result register.
// ----------------------------------------------------------------------------
module frml_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sample_vld,
    output logic              o_sample_rdy,
    input  frml_pkg::t_dp_sts i_sts,
    output frml_pkg::t_dp_cmd o_cmd
);
    import frml_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_sample_rdy = 1'b0;
        unique case (r_state)
            S_ACC: begin
                o_sample_rdy = 1'b1;
                o_cmd.acc    = i_sample_vld;
                if (i_sample_vld && i_sts.close) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.step_last) begin
                    n_state = S_SQ_LOAD;
                end
            end
            S_SQ_LOAD: begin
                o_cmd.sq_load = 1'b1;
                n_state       = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sq_step = 1'b1;
                if (i_sts.step_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

endmodule

// File: rtl/frml_datapath.sv
// ----------------------------------------------------------------------------
// frml_datapath: arithmetic of the frame RMS level meter
// Square and accumulate, frame and packet counters, a bit-serial restoring
// divider, a bit-serial integer square root and the result register.
// ----------------------------------------------------------------------------
module frml_datapath #(
    parameter int MAX_FRAME_LENGTH = 4096,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [frml_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [frml_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    input  frml_pkg::t_dp_cmd               i_cmd,
    output frml_pkg::t_dp_sts               o_sts,
    input  logic                            i_out_rdy,
    output logic                            o_out_vld,
    output logic [frml_pkg::LEVEL_W-1:0]    o_level,
    output logic                            o_packet_end
);
    import frml_pkg::*;

    localparam int CNT_W  = $clog2(MAX_FRAME_LENGTH + 1);
    localparam int LEN_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SUM_W  = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int RAD_W  = SUM_W + (SUM_W % 2);
    localparam int RT_W   = RAD_W / 2;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SUM_W - 1);
    localparam logic [STEP_W-1:0] SQ_LAST  = STEP_W'(RT_W - 1);
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_FRAME_LENGTH);

    // configuration registers
    logic [CFG_W-1:0] r_frame_len;
    logic [CFG_W-1:0] r_packet_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len  <= FRAME_LENGTH_RST;
            r_packet_len <= PACKET_LENGTH_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_FRAME_LENGTH) begin
                r_frame_len <= i_cfg_data;
            end
            if (i_cfg_idx == REG_PACKET_LENGTH) begin
                r_packet_len <= i_cfg_data;
            end
        end
    end

    // magnitude and square of the sample; the most negative code maps to 2^(n-1)
    logic [SAMPLE_BITS-1:0]   mag;
    logic [2*SAMPLE_BITS-1:0] square;

    assign mag    = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
    assign square = mag * mag;

    // effective frame length: zero acts as one, saturate at the maximum
    logic [LEN_W-1:0] len_raw;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] cnt_inc;
    logic [CNT_W-1:0] r_count;

    assign len_raw = LEN_W'(r_frame_len);

    always_comb begin
        priority if (len_raw == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_raw > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = len_raw;
        end
    end

    assign cnt_inc     = LEN_W'(r_count) + LEN_W'(1);
    assign o_sts.close = (cnt_inc >= len_eff);

    // square register, sum and frame count
    logic [SUM_W-1:0] r_sq;
    logic [SUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq    <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_sq <= i_cmd.acc ? SUM_W'(square) : '0;
            if (i_cmd.finish) begin
                r_sum <= '0;
            end else begin
                r_sum <= r_sum + r_sq;
            end
            if (i_cmd.acc) begin
                r_count <= o_sts.close ? '0 : cnt_inc[CNT_W-1:0];
            end
        end
    end

    // shared iteration counter
    logic [STEP_W-1:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.finish || i_cmd.sq_load) begin
            r_step <= '0;
        end else if (i_cmd.div_step || i_cmd.sq_step) begin
            r_step <= r_step + 1'b1;
        end
    end

    assign o_sts.step_last = (i_cmd.div_step && (r_step == DIV_LAST)) ||
                             (i_cmd.sq_step  && (r_step == SQ_LAST));

    // restoring divider: sum / sample count, quotient shifts in at the bottom
    logic [SUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_div;
    logic [CNT_W:0]   div_sh;
    logic [CNT_W:0]   div_diff;
    logic             div_ge;

    assign div_sh   = {r_rem, r_quo[SUM_W-1]};
    assign div_ge   = (div_sh >= {1'b0, r_div});
    assign div_diff = div_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && o_sts.close) begin
            r_div <= cnt_inc[CNT_W-1:0];
        end
        if (i_cmd.finish) begin
            r_quo <= r_sum + r_sq;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], div_ge};
            r_rem <= div_ge ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
        end
    end

    // digit-by-digit square root, two radicand bits per iteration
    logic [RAD_W-1:0] r_rad;
    logic [RT_W-1:0]  r_root;
    logic [RT_W:0]    r_sq_rem;
    logic [RT_W+2:0]  sq_sh;
    logic [RT_W+2:0]  sq_trial;
    logic [RT_W+2:0]  sq_diff;
    logic             sq_ge;

    assign sq_sh    = {r_sq_rem, r_rad[RAD_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);
    assign sq_diff  = sq_sh - sq_trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_load) begin
            r_rad    <= RAD_W'(r_quo);
            r_root   <= '0;
            r_sq_rem <= '0;
        end else if (i_cmd.sq_step) begin
            r_rad    <= {r_rad[RAD_W-3:0], 2'b00};
            r_root   <= {r_root[RT_W-2:0], sq_ge};
            r_sq_rem <= sq_ge ? sq_diff[RT_W:0] : sq_sh[RT_W:0];
        end
    end

    // packet counter and result register
    logic [CFG_W-1:0]        r_pkt_count;
    logic [CFG_W:0]          pkt_inc;
    logic                    pkt_end;
    logic [RT_W+LEVEL_W-1:0] root_ext;
    logic                    r_out_vld;
    logic [LEVEL_W-1:0]      r_level;
    logic                    r_last;

    assign pkt_inc  = {1'b0, r_pkt_count} + 1'b1;
    assign pkt_end  = (pkt_inc >= {1'b0, r_packet_len});
    assign root_ext = {{LEVEL_W{1'b0}}, r_root};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_count <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_pkt_count <= pkt_end ? '0 : pkt_inc[CFG_W-1:0];
                r_out_vld   <= 1'b1;
            end else if (i_out_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_level <= root_ext[LEVEL_W-1:0];
            r_last  <= pkt_end;
        end
    end

    assign o_sts.out_free = !r_out_vld || i_out_rdy;
    assign o_out_vld      = r_out_vld;
    assign o_level        = r_level;
    assign o_packet_end   = r_last;

    // checks
    a_count_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(MAX_FRAME_LENGTH))
        else $error("frame count reached the maximum frame length");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_root_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sq_step |-> (r_sq_rem <= {r_root, 1'b0}))
        else $error("root remainder above twice the partial root");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || i_out_rdy))
        else $error("pending result overwritten");

endmodule
